// ----- rtl/tcgr_pkg.sv -----
// shared types and constants of the text console glyph renderer
package tcgr_pkg;

	// storage defaults for the top level parameters
	localparam int FONT_BYTES_DEF  = 4096;
	localparam int MAP_ENTRIES_DEF = 128;

	// glyph size limits, fixed by the 32-bit row word
	localparam int MAX_GLYPH_ROWS  = 32;
	localparam int MAX_GLYPH_WIDTH = 32;

	localparam int OFFS_W     = 26;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COLS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_COUNT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_STRIDE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_ENABLE   = 3'd7;

	// register reset values
	localparam logic [15:0] PITCH_RST        = 16'd4096;
	localparam logic [10:0] SCREEN_COLS_RST  = 11'd80;
	localparam logic [10:0] SCREEN_ROWS_RST  = 11'd25;
	localparam logic [5:0]  GLYPH_WIDTH_RST  = 6'd8;
	localparam logic [5:0]  GLYPH_HEIGHT_RST = 6'd16;
	localparam logic [9:0]  GLYPH_COUNT_RST  = 10'd256;
	localparam logic [7:0]  GLYPH_STRIDE_RST = 8'd16;

	// request types
	localparam logic [1:0] REQ_FONT = 2'd0;
	localparam logic [1:0] REQ_MAP  = 2'd1;
	localparam logic [1:0] REQ_PUT  = 2'd2;

	// character codes
	localparam logic [7:0] NEWLINE_CODE = 8'h0A;
	localparam logic [7:0] PRINT_LO     = 8'h20;
	localparam logic [7:0] PRINT_HI     = 8'h7E;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [11:0] store_index;
		logic [8:0]  store_value;
		logic [7:0]  char_code;
	} req_item_t;

	typedef struct packed {
		logic [OFFS_W-1:0] row_offset;
		logic [31:0]       row_bits;
		logic              last_row;
	} res_item_t;

	// one character's row job handed to the row fetch sequencer
	typedef struct packed {
		logic [OFFS_W-1:0] offs;
		logic [15:0]       pitch;
		logic [5:0]        rows;
		logic [2:0]        nbytes;
		logic [31:0]       mask;
	} rend_job_t;

endpackage

// ----- rtl/tcgr_ram.sv -----
// generic single write port ram with registered read
module tcgr_ram
	import tcgr_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/tcgr_render.sv -----
// glyph row fetch sequencer and result register
module tcgr_render
	import tcgr_pkg::*;
#(
	parameter int FONT_BYTES = FONT_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  rend_job_t                     job,
	input  logic [$clog2(FONT_BYTES)-1:0] job_base,
	output logic                          busy,
	output logic                          font_rd_en,
	output logic [$clog2(FONT_BYTES)-1:0] font_rd_addr,
	input  logic [7:0]                    font_rd_data,
	output logic                          res_valid,
	input  logic                          res_stall,
	output res_item_t                     res_item
);

	localparam int FAW = $clog2(FONT_BYTES);

	typedef enum logic [2:0] {
		R_IDLE  = 3'b001,
		R_FETCH = 3'b010,
		R_DRAIN = 3'b100
	} rstate_t;

	rstate_t           state_q;
	rend_job_t         job_q;
	logic [FAW-1:0]    addr_q;
	logic [1:0]        k_q;
	logic [4:0]        y_q;
	logic [OFFS_W-1:0] offs_q;
	logic [31:0]       acc_q;
	logic              pend_s1;
	logic [1:0]        k_s1;
	logic              lastb_s1;
	logic              lastr_s1;
	res_item_t         res_item_q;

	logic        out_free;
	logic        complete;
	logic        hold;
	logic        issue;
	logic        is_lastb;
	logic        is_lastr;
	logic [31:0] word;

	function automatic logic [31:0] place_byte(input logic [7:0] b, input logic [1:0] k);
		logic [31:0] w;
		w = '0;
		unique case (k)
			2'd0: w[31:24] = b;
			2'd1: w[23:16] = b;
			2'd2: w[15:8]  = b;
			2'd3: w[7:0]   = b;
			default: w = '0;
		endcase
		return w;
	endfunction

	// last byte of a row waits in the ram output until the result register frees
	assign out_free = !res_valid || !res_stall;
	assign complete = pend_s1 && (!lastb_s1 || out_free);
	assign hold     = pend_s1 && !complete;
	assign issue    = (state_q == R_FETCH) && !hold;
	assign is_lastb = ({1'b0, k_q} == (job_q.nbytes - 3'd1));
	assign is_lastr = ({1'b0, y_q} == (job_q.rows - 6'd1));
	assign word     = acc_q | place_byte(font_rd_data, k_s1);

	assign busy         = (state_q != R_IDLE);
	assign font_rd_en   = issue;
	assign font_rd_addr = addr_q;
	assign res_item     = res_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= R_IDLE;
			pend_s1   <= 1'b0;
			k_q       <= 2'd0;
			y_q       <= 5'd0;
			res_valid <= 1'b0;
		end else begin
			if (complete && lastb_s1) begin
				res_valid <= 1'b1;
			end else if (!res_stall) begin
				res_valid <= 1'b0;
			end

			if (issue) begin
				pend_s1 <= 1'b1;
			end else if (complete) begin
				pend_s1 <= 1'b0;
			end

			unique case (state_q)
				R_IDLE: begin
					if (start) begin
						state_q <= R_FETCH;
						k_q     <= 2'd0;
						y_q     <= 5'd0;
					end
				end
				R_FETCH: begin
					if (issue) begin
						if (is_lastb) begin
							k_q <= 2'd0;
							y_q <= y_q + 5'd1;
							if (is_lastr) begin
								state_q <= R_DRAIN;
							end
						end else begin
							k_q <= k_q + 2'd1;
						end
					end
				end
				R_DRAIN: begin
					if (complete) begin
						state_q <= R_IDLE;
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == R_IDLE) && start) begin
			job_q  <= job;
			addr_q <= job_base;
			offs_q <= job.offs;
			acc_q  <= '0;
		end else begin
			if (issue) begin
				addr_q   <= addr_q + FAW'(1);
				k_s1     <= k_q;
				lastb_s1 <= is_lastb;
				lastr_s1 <= is_lastr;
			end
			if (complete) begin
				if (lastb_s1) begin
					res_item_q.row_offset <= offs_q;
					res_item_q.row_bits   <= word & job_q.mask;
					res_item_q.last_row   <= lastr_s1;
					offs_q                <= offs_q + OFFS_W'(job_q.pitch);
					acc_q                 <= '0;
				end else begin
					acc_q <= word;
				end
			end
		end
	end

endmodule

// ----- rtl/text_console_glyph_renderer_core.sv -----
// text console glyph renderer top level: requests, map, cursor, offset setup
// font and map loads and newlines are handled as they are accepted; a printable character
// goes through setup (map read, multiplies, offset sum), then max(1, ceil(width/8)) font
// bytes are read per glyph row on the single font read port, followed by a drain; an 8x16
// font gives 16 row items, one per cycle when results are taken
// reset clears cursor, registers and map valid bits; font contents are undefined until loaded
module text_console_glyph_renderer_core
	import tcgr_pkg::*;
#(
	parameter int FONT_BYTES  = FONT_BYTES_DEF,
	parameter int MAP_ENTRIES = MAP_ENTRIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_item_t             req_item,
	output logic                  res_valid,
	input  logic                  res_stall,
	output res_item_t             res_item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int FAW = $clog2(FONT_BYTES);
	localparam int MAW = $clog2(MAP_ENTRIES);
	localparam logic [10:0] DIM_MAX = 11'd1024;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MAP  = 4'b0010,
		ST_OFFS = 4'b0100,
		ST_REND = 4'b1000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [15:0] pitch_q;
	logic [10:0] screen_cols_q;
	logic [10:0] screen_rows_q;
	logic [5:0]  glyph_width_q;
	logic [5:0]  glyph_height_q;
	logic [9:0]  glyph_count_q;
	logic [7:0]  glyph_stride_q;
	logic        map_enable_q;

	// cursor
	logic [9:0] cursor_col_q;
	logic [9:0] cursor_row_q;

	// per character setup registers
	logic [7:0]     ch_q;
	logic           map_vld_s1;
	logic [FAW-1:0] base_q;
	logic [15:0]    rowpx_q;
	logic [15:0]    colpx_q;

	// map valid bits, one per entry, stand in for a cleared map
	logic [MAP_ENTRIES-1:0] map_vld_q;

	logic           req_accept;
	logic           is_put;
	logic           is_newline;
	logic           is_print;
	logic           font_wr_en;
	logic           map_wr_en;
	logic [MAW-1:0] map_wr_addr;
	logic [MAW-1:0] map_rd_addr;
	logic           map_rd_en;
	logic [8:0]     map_rd_data;
	logic           font_rd_en;
	logic [FAW-1:0] font_rd_addr;
	logic [7:0]     font_rd_data;

	logic [5:0]  gw_eff;
	logic [5:0]  gh_eff;
	logic [5:0]  gw_p7;
	logic [5:0]  gw_p1;
	logic [2:0]  bpl;
	logic [2:0]  nbytes;
	logic [31:0] row_mask;
	logic [10:0] cols_eff;
	logic [10:0] rows_eff;
	logic        col_wrap;
	logic        row_wrap;

	logic [8:0]  code_raw;
	logic [8:0]  code;
	logic [16:0] base_prod;
	logic [15:0] rowpx_d;
	logic [15:0] colpx_d;
	logic [31:0] offs_full;

	logic      rend_start;
	logic      rend_busy;
	rend_job_t rend_job;

	function automatic logic [10:0] clamp_dim(input logic [10:0] v);
		logic [10:0] r;
		if (v == 11'd0) begin
			r = 11'd1;
		end else if (v > DIM_MAX) begin
			r = DIM_MAX;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// handshakes: items only enter while no character is in flight
	assign req_stall  = (state_q != ST_IDLE);
	assign req_accept = req_valid && !req_stall;
	assign cfg_ready  = 1'b1;

	// request decode
	assign is_put     = (req_item.req_type == REQ_PUT);
	assign is_newline = is_put && (req_item.char_code == NEWLINE_CODE);
	assign is_print   = is_put && (req_item.char_code >= PRINT_LO) &&
	                    (req_item.char_code <= PRINT_HI);

	assign font_wr_en  = req_accept && (req_item.req_type == REQ_FONT);
	assign map_wr_en   = req_accept && (req_item.req_type == REQ_MAP) &&
	                     ({1'b0, req_item.store_index} < 13'(MAP_ENTRIES));
	assign map_wr_addr = MAW'(req_item.store_index);
	// printable codes sit below the default map size of 128, so no wrap is needed there
	assign map_rd_addr = MAW'(req_item.char_code);
	assign map_rd_en   = req_accept && is_print;

	// effective glyph geometry
	assign gw_eff   = (glyph_width_q > 6'(MAX_GLYPH_WIDTH)) ? 6'(MAX_GLYPH_WIDTH) : glyph_width_q;
	assign gh_eff   = (glyph_height_q > 6'(MAX_GLYPH_ROWS)) ? 6'(MAX_GLYPH_ROWS) : glyph_height_q;
	assign gw_p7    = gw_eff + 6'd7;
	assign gw_p1    = gw_eff + 6'd1;
	assign bpl      = gw_p7[5:3];
	// zero width still fetches one byte a row, the mask blanks it
	assign nbytes   = (bpl == 3'd0) ? 3'd1 : bpl;
	assign row_mask = ~(32'hFFFF_FFFF >> gw_eff);

	// cursor wrap
	assign cols_eff = clamp_dim(screen_cols_q);
	assign rows_eff = clamp_dim(screen_rows_q);
	assign col_wrap = (({1'b0, cursor_col_q}) + 11'd1) >= cols_eff;
	assign row_wrap = (({1'b0, cursor_row_q}) + 11'd1) >= rows_eff;

	// glyph selection, map entries never written read as zero
	assign code_raw  = map_enable_q ? (map_vld_s1 ? map_rd_data : 9'd0) : {1'b0, ch_q};
	assign code      = ((code_raw == 9'd0) || ({1'b0, code_raw} >= glyph_count_q)) ?
	                   9'd0 : code_raw;
	assign base_prod = code * glyph_stride_q;
	assign rowpx_d   = cursor_row_q * gh_eff;
	assign colpx_d   = cursor_col_q * gw_p1;

	// first row offset, four bytes per pixel
	assign offs_full = (rowpx_q * pitch_q) + {14'd0, colpx_q, 2'b00};

	assign rend_start      = (state_q == ST_OFFS) && (gh_eff != 6'd0);
	assign rend_job.offs   = offs_full[OFFS_W-1:0];
	assign rend_job.pitch  = pitch_q;
	assign rend_job.rows   = gh_eff;
	assign rend_job.nbytes = nbytes;
	assign rend_job.mask   = row_mask;

	tcgr_ram #(
		.WIDTH(8),
		.DEPTH(FONT_BYTES)
	) u_font_ram (
		.clk     (clk),
		.wr_en   (font_wr_en),
		.wr_addr (FAW'(req_item.store_index)),
		.wr_data (req_item.store_value[7:0]),
		.rd_en   (font_rd_en),
		.rd_addr (font_rd_addr),
		.rd_data (font_rd_data)
	);

	tcgr_ram #(
		.WIDTH(9),
		.DEPTH(MAP_ENTRIES)
	) u_map_ram (
		.clk     (clk),
		.wr_en   (map_wr_en),
		.wr_addr (map_wr_addr),
		.wr_data (req_item.store_value),
		.rd_en   (map_rd_en),
		.rd_addr (map_rd_addr),
		.rd_data (map_rd_data)
	);

	tcgr_render #(
		.FONT_BYTES(FONT_BYTES)
	) u_render (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (rend_start),
		.job          (rend_job),
		.job_base     (base_q),
		.busy         (rend_busy),
		.font_rd_en   (font_rd_en),
		.font_rd_addr (font_rd_addr),
		.font_rd_data (font_rd_data),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.res_item     (res_item)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q        <= PITCH_RST;
			screen_cols_q  <= SCREEN_COLS_RST;
			screen_rows_q  <= SCREEN_ROWS_RST;
			glyph_width_q  <= GLYPH_WIDTH_RST;
			glyph_height_q <= GLYPH_HEIGHT_RST;
			glyph_count_q  <= GLYPH_COUNT_RST;
			glyph_stride_q <= GLYPH_STRIDE_RST;
			map_enable_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PITCH:        pitch_q        <= cfg_data;
				CFG_SCREEN_COLS:  screen_cols_q  <= cfg_data[10:0];
				CFG_SCREEN_ROWS:  screen_rows_q  <= cfg_data[10:0];
				CFG_GLYPH_WIDTH:  glyph_width_q  <= cfg_data[5:0];
				CFG_GLYPH_HEIGHT: glyph_height_q <= cfg_data[5:0];
				CFG_GLYPH_COUNT:  glyph_count_q  <= cfg_data[9:0];
				CFG_GLYPH_STRIDE: glyph_stride_q <= cfg_data[7:0];
				CFG_MAP_ENABLE:   map_enable_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer, cursor and map valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cursor_col_q <= 10'd0;
			cursor_row_q <= 10'd0;
			map_vld_q    <= '0;
		end else begin
			if (map_wr_en) begin
				map_vld_q[map_wr_addr] <= 1'b1;
			end

			// newline on entry, advance after the offset is taken
			if (req_accept && is_newline) begin
				cursor_col_q <= 10'd0;
				cursor_row_q <= row_wrap ? 10'd0 : (cursor_row_q + 10'd1);
			end else if (state_q == ST_OFFS) begin
				if (col_wrap) begin
					cursor_col_q <= 10'd0;
					cursor_row_q <= row_wrap ? 10'd0 : (cursor_row_q + 10'd1);
				end else begin
					cursor_col_q <= cursor_col_q + 10'd1;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (map_rd_en) begin
						state_q <= ST_MAP;
					end
				end
				ST_MAP:  state_q <= ST_OFFS;
				ST_OFFS: state_q <= (gh_eff != 6'd0) ? ST_REND : ST_IDLE;
				ST_REND: begin
					if (!rend_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// per character setup data
	always_ff @(posedge clk) begin
		if (map_rd_en) begin
			ch_q       <= req_item.char_code;
			map_vld_s1 <= map_vld_q[map_rd_addr];
		end
		if (state_q == ST_MAP) begin
			base_q  <= base_prod[FAW-1:0];
			rowpx_q <= rowpx_d;
			colpx_q <= colpx_d;
		end
	end

	// renderer is idle whenever the front end is idle
	a_idle_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !rend_busy)
		else $error("renderer busy while front end idle");

	// a new job only starts on an idle renderer
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rend_start |-> !rend_busy)
		else $error("render job started while busy");

	// font loads never overlap glyph fetches
	a_font_wr_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		font_wr_en |-> !rend_busy)
		else $error("font write during glyph fetch");

	// cursor moves only for an accepted item or a character advance
	a_cursor_move: assert property (@(posedge clk) disable iff (!arst_n)
		!($stable(cursor_col_q) && $stable(cursor_row_q)) |->
		($past(req_accept) || $past(state_q == ST_OFFS)))
		else $error("cursor moved without cause");

endmodule
